>>> rtl/sgm_pkg.sv
// Package for the Sobel gradient magnitude core: geometry limits, codes, command and status types.
// No dependencies.
`default_nettype none
package sgm_pkg;
  localparam int MaxWidthDef = 2048;
  localparam int LanesDef    = 4;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgChan   = 2'd2;
  localparam logic [1:0] CfgGray   = 2'd3;

  localparam logic [11:0] WidthRst  = 12'd640;
  localparam logic [15:0] HeightRst = 16'd480;
  localparam logic [2:0]  ChanRst   = 3'd3;

  localparam logic [16:0] LumaW0 = 17'd13933;
  localparam logic [16:0] LumaW1 = 17'd46871;
  localparam logic [16:0] LumaW2 = 17'd4732;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch a new pixel and read the line stores
    logic shift;      // write line stores, shift the window
    logic emit_edge;  // emit for the right image edge (window shifted with zeros)
    logic clr_win;    // zero the window
    logic start_mag;  // start the magnitude unit
    logic top_ok;     // row >= 2
    logic mid_ok;     // row >= 1
    logic pix_ok;     // sample is a real pixel
    logic gray;
    logic [2:0] ch;
  } sgm_cmd_t;

  typedef struct packed {
    logic mag_done;
  } sgm_stat_t;
endpackage
`default_nettype wire

>>> rtl/sgm_datapath.sv
// Datapath: luma, line stores, 3x3 window, Sobel sums and bit-serial root.
// Depends on sgm_pkg.
`default_nettype none
module sgm_datapath #(
  parameter int MAX_WIDTH = sgm_pkg::MaxWidthDef,
  parameter int LANES     = sgm_pkg::LanesDef,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk,
  input  wire sgm_pkg::sgm_cmd_t cmd,
  output sgm_pkg::sgm_stat_t   stat,
  input  wire logic [AW-1:0]   col,
  input  wire logic [7:0]      pix_ch0,
  input  wire logic [7:0]      pix_ch1,
  input  wire logic [7:0]      pix_ch2,
  input  wire logic [7:0]      pix_ch3,
  output logic [7:0]           mag_r [4],
  input  wire logic            rst_n
);
  logic [31:0] lp_mem [MAX_WIDTH];
  logic [31:0] lp2_mem [MAX_WIDTH];
  logic [31:0] lp_rd_r, lp2_rd_r, s_r;
  logic [31:0] win_r [9];
  logic [31:0] s_nxt;
  logic [33:0] luma;
  logic [7:0]  y;
  logic [31:0] w [9];
  logic [16:0] sq_r [4];
  logic [7:0]  m_r [4];
  logic [3:0]  bit_r;
  logic        busy_r;
  logic [3:0]  bit_nxt;

  always_comb begin
    s_nxt = '0;
    if (cmd.pix_ok) begin
      s_nxt[7:0] = pix_ch0;
      if (cmd.ch >= 3'd2) s_nxt[15:8] = pix_ch1;
      if (cmd.ch >= 3'd3) s_nxt[23:16] = pix_ch2;
      if (cmd.ch >= 3'd4 && LANES > 3) s_nxt[31:24] = pix_ch3;
    end
    luma = 34'(sgm_pkg::LumaW0 * s_nxt[7:0]) + 34'(sgm_pkg::LumaW1 * s_nxt[15:8])
         + 34'(sgm_pkg::LumaW2 * s_nxt[23:16]);
    y = luma[23:16];
    if (cmd.gray && cmd.pix_ok) s_nxt[23:0] = {y, y, y};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r      <= s_nxt;
      lp_rd_r  <= lp_mem[col];
      lp2_rd_r <= lp2_mem[col];
    end
    if (cmd.shift) begin
      lp_mem[col]  <= s_r;
      lp2_mem[col] <= lp_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_win) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      for (int i = 0; i < 6; i++) win_r[i] <= win_r[i+3];
      win_r[6] <= cmd.top_ok ? lp2_rd_r : 32'd0;
      win_r[7] <= cmd.mid_ok ? lp_rd_r : 32'd0;
      win_r[8] <= s_r;
    end
  end

  // window as seen by the Sobel sums (edge case: shifted in zeros)
  always_comb begin
    for (int i = 0; i < 9; i++) w[i] = win_r[i];
    if (cmd.emit_edge) begin
      for (int i = 0; i < 6; i++) w[i] = win_r[i+3];
      for (int i = 6; i < 9; i++) w[i] = '0;
    end
  end

  // Sobel and square sum, then bit-serial root, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else if (cmd.start_mag) begin
      busy_r <= 1'b1;
      bit_r  <= 4'd8;
    end else if (busy_r) begin
      bit_r <= bit_nxt;
      if (bit_r == 4'd1) busy_r <= 1'b0;
    end
  end
  assign bit_nxt = bit_r - 4'd1;
  assign stat.mag_done = busy_r && bit_r == 4'd1;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [10:0] gx, gy;
    logic [20:0] sum;
    logic [7:0]  cand;
    logic [15:0] csq;
    always_comb begin
      gx = 11'(w[6][8*k+:8]) + 11'({w[7][8*k+:8], 1'b0}) + 11'(w[8][8*k+:8])
         - 11'(w[0][8*k+:8]) - 11'({w[1][8*k+:8], 1'b0}) - 11'(w[2][8*k+:8]);
      gy = 11'(w[2][8*k+:8]) + 11'({w[5][8*k+:8], 1'b0}) + 11'(w[8][8*k+:8])
         - 11'(w[0][8*k+:8]) - 11'({w[3][8*k+:8], 1'b0}) - 11'(w[6][8*k+:8]);
      sum  = 21'(gx * gx) + 21'(gy * gy);
      cand = m_r[k] | (8'd1 << bit_nxt[2:0]);
      csq  = cand * cand;
    end
    always_ff @(posedge clk) begin
      if (cmd.start_mag) begin
        m_r[k]  <= '0;
        // saturate: anything at or past 255^2 acts as 65535
        if (3'(k) >= cmd.ch || k >= LANES) sq_r[k] <= '0;
        else sq_r[k] <= (sum >= 21'd65025) ? 17'd65535 : 17'(sum);
      end else if (busy_r && {1'b0, csq} <= sq_r[k]) begin
        m_r[k] <= cand;
      end
    end
    assign mag_r[k] = m_r[k];
  end
endmodule
`default_nettype wire

>>> rtl/sgm_ctrl.sv
// Controller: image position counters, geometry latch, handshake sequencing.
// Depends on sgm_pkg.
`default_nettype none
module sgm_ctrl #(
  parameter int MAX_WIDTH = sgm_pkg::MaxWidthDef,
  parameter int LANES     = sgm_pkg::LanesDef,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_last_pixel,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output sgm_pkg::sgm_cmd_t      cmd,
  input  wire sgm_pkg::sgm_stat_t stat,
  output logic [AW-1:0]          col
);
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EDGE = 3'd2,
                         S_EDGEW = 3'd3, S_SHIFT = 3'd4, S_MAIN = 3'd5,
                         S_MAINW = 3'd6, S_OUT = 3'd7;
  localparam logic [AW:0] MaxW = (AW+1)'(MAX_WIDTH);

  logic [2:0]  st_r, st_nxt;
  logic [11:0] w_cfg_r;
  logic [15:0] h_cfg_r;
  logic [2:0]  ch_cfg_r;
  logic        g_cfg_r;
  logic [AW:0] lat_w_r;
  logic [15:0] lat_h_r;
  logic [2:0]  lat_ch_r;
  logic        lat_g_r;
  logic [16:0] in_row_r;
  logic [AW:0] in_col_r;
  logic [15:0] out_row_r;
  logic [AW:0] out_col_r;
  logic        last_r, after_r;
  logic        accept, start;
  logic [AW:0] w_eff;
  logic [15:0] h_eff;
  logic [2:0]  ch_eff;

  assign accept   = in_valid && !in_stall;
  assign in_stall = st_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = st_r == S_OUT;
  assign out_last_pixel = last_r;
  assign col = in_col_r[AW-1:0];
  assign start = in_row_r == '0 && in_col_r == '0;

  always_comb begin
    if (w_cfg_r == '0) w_eff = (AW+1)'(1);
    else if (14'(w_cfg_r) > 14'(MAX_WIDTH)) w_eff = MaxW;
    else w_eff = (AW+1)'(w_cfg_r);
    h_eff = h_cfg_r == '0 ? 16'd1 : h_cfg_r;
    if (ch_cfg_r == '0) ch_eff = 3'd1;
    else if (ch_cfg_r > 3'(LANES)) ch_eff = 3'(LANES);
    else ch_eff = ch_cfg_r;
  end

  always_comb begin
    cmd = '0;
    cmd.ch     = start ? ch_eff : lat_ch_r;
    cmd.gray   = start ? (g_cfg_r && ch_eff >= 3'd3) : lat_g_r;
    cmd.pix_ok = !in_cmd && (start || 17'(lat_h_r) > in_row_r);
    cmd.load   = accept;
    cmd.top_ok = in_row_r >= 17'd2;
    cmd.mid_ok = in_row_r >= 17'd1;
    cmd.emit_edge = st_r == S_EDGE;
    cmd.start_mag = (st_r == S_EDGE) || (st_r == S_MAIN);
    cmd.clr_win   = st_r == S_EDGEW && (stat.mag_done || in_row_r < 17'd2);
    cmd.shift     = st_r == S_SHIFT;
  end

  function automatic logic is_last(input logic [15:0] r, input logic [AW:0] c,
                                   input logic [15:0] h, input logic [AW:0] wd);
    is_last = (17'(r) + 17'd1 == 17'(h)) && (c + 1'b1 == wd);
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (accept) st_nxt = S_READ;
      S_READ:  if (in_col_r == '0 && in_row_r >= 17'd2) st_nxt = S_EDGE;
               else if (in_col_r == '0) st_nxt = S_EDGEW;
               else st_nxt = S_SHIFT;
      S_EDGE:  st_nxt = S_EDGEW;
      // the edge result leaves through S_OUT before the shift
      S_EDGEW: if (stat.mag_done) st_nxt = S_OUT;
               else if (in_row_r < 17'd2) st_nxt = S_SHIFT;
      S_SHIFT: st_nxt = (in_col_r != '0 && in_row_r != '0) ? S_MAIN :
                        (after_r ? S_OUT : S_IDLE);
      S_MAIN:  st_nxt = S_MAINW;
      S_MAINW: if (stat.mag_done) st_nxt = S_OUT;
      S_OUT:   if (!out_stall) st_nxt = after_r ? S_SHIFT : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      w_cfg_r <= sgm_pkg::WidthRst; h_cfg_r <= sgm_pkg::HeightRst;
      ch_cfg_r <= sgm_pkg::ChanRst; g_cfg_r <= 1'b1;
      lat_w_r <= (AW+1)'(640); lat_h_r <= sgm_pkg::HeightRst;
      lat_ch_r <= sgm_pkg::ChanRst; lat_g_r <= 1'b1;
      in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
      last_r <= 1'b0; after_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          sgm_pkg::CfgWidth:  w_cfg_r  <= cfg_data[11:0];
          sgm_pkg::CfgHeight: h_cfg_r  <= cfg_data;
          sgm_pkg::CfgChan:   ch_cfg_r <= cfg_data[2:0];
          sgm_pkg::CfgGray:   g_cfg_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        after_r <= 1'b0;
        if (start) begin
          lat_w_r <= w_eff; lat_h_r <= h_eff;
          lat_ch_r <= ch_eff; lat_g_r <= g_cfg_r && ch_eff >= 3'd3;
        end
      end
      // advance the output position for every result: edge (issued at column zero) or main
      if (st_r == S_EDGE || st_r == S_MAIN) begin
        last_r <= is_last(out_row_r, out_col_r, lat_h_r, lat_w_r);
        if (out_col_r + 1'b1 >= lat_w_r) begin
          out_col_r <= '0; out_row_r <= out_row_r + 16'd1;
        end else out_col_r <= out_col_r + 1'b1;
      end
      if (st_r == S_EDGEW && stat.mag_done) after_r <= 1'b1;
      if (st_r == S_OUT && !out_stall && after_r) after_r <= 1'b0;
      if (st_r == S_SHIFT) begin
        if (last_r && !(in_col_r != '0 && in_row_r != '0)) begin
          in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
          last_r <= 1'b0;
        end else if (in_col_r + 1'b1 >= lat_w_r) begin
          in_col_r <= '0; in_row_r <= in_row_r + 17'd1;
        end else in_col_r <= in_col_r + 1'b1;
      end
      if (st_r == S_OUT && !out_stall && !after_r && last_r) begin
        in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
        last_r <= 1'b0;
      end else if (st_r == S_OUT && !out_stall && !after_r) last_r <= 1'b0;
    end
  end
  // edge result that was last: counters reset after the shift (handled above)
endmodule
`default_nettype wire

>>> rtl/sobel_gradient_magnitude_core.sv
// Top level of the streaming Sobel gradient magnitude core.
// Depends on sgm_pkg, sgm_ctrl and sgm_datapath.
//
// Usage:
//   Pixels enter in raster order on the in_ channel (valid/stall); cmd 1 marks
//   a flush transaction that counts as a pixel outside the image. Each
//   transaction gives zero or one result on the out_ channel: four 8-bit
//   magnitudes and last_pixel. The result for pixel q comes with transaction
//   q + width + 1, so width + 1 flush transactions drain an image.
//   A transaction with a result waits for the 8-step bit-serial square root
//   shared by all lanes; out_valid rises once that root pass is done. Each
//   transaction runs at most one root pass, and the block works on one
//   transaction at a time.
//   Configuration: write registers on cfg_ only while idle; geometry is
//   latched when the first pixel of an image is taken.
//   Reset (rst_n low, synchronous) returns counters and registers to their
//   defaults; line stores stay undefined and their old contents are never used.
//   While out_stall is high the result holds and no input is taken.
`default_nettype none
module sobel_gradient_magnitude_core #(
  parameter int MAX_WIDTH = sgm_pkg::MaxWidthDef,
  parameter int LANES     = sgm_pkg::LanesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_pix_ch0,
  input  wire logic [7:0]  in_pix_ch1,
  input  wire logic [7:0]  in_pix_ch2,
  input  wire logic [7:0]  in_pix_ch3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_mag_ch0,
  output logic [7:0]       out_mag_ch1,
  output logic [7:0]       out_mag_ch2,
  output logic [7:0]       out_mag_ch3,
  output logic             out_last_pixel,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH);
  sgm_pkg::sgm_cmd_t  cmd;
  sgm_pkg::sgm_stat_t stat;
  logic [AW-1:0] col;
  logic [7:0] mag [4];

  sgm_ctrl #(.MAX_WIDTH(MAX_WIDTH), .LANES(LANES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .out_valid, .out_stall,
    .out_last_pixel, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .cmd, .stat, .col
  );

  sgm_datapath #(.MAX_WIDTH(MAX_WIDTH), .LANES(LANES)) u_dp (
    .clk, .cmd, .stat, .col, .pix_ch0(in_pix_ch0), .pix_ch1(in_pix_ch1),
    .pix_ch2(in_pix_ch2), .pix_ch3(in_pix_ch3), .mag_r(mag), .rst_n
  );

  // hold the result of the last root pass until taken
  assign out_mag_ch0 = mag[0];
  assign out_mag_ch1 = mag[1];
  assign out_mag_ch2 = mag[2];
  assign out_mag_ch3 = mag[3];
endmodule
`default_nettype wire

>>> tb/tb_sobel_gradient_magnitude_core.sv
// Self-checking testbench for sobel_gradient_magnitude_core: streams whole images
// and compares every magnitude result against a built-in 3x3 Sobel predictor.
// Depends on sgm_pkg and the RTL of the core.
`timescale 1ns / 1ps
module tb_sobel_gradient_magnitude_core;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;
  localparam int   MaxW     = sgm_pkg::MaxWidthDef;
  localparam int   TimeoutCycles = 3000000;
  localparam int   DrainCycles   = 40;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch3;
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] ch0;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] m3;
    logic       last;
  } mag_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_cmd = 1'b0;
  logic [7:0] in_pix_ch0 = '0, in_pix_ch1 = '0, in_pix_ch2 = '0, in_pix_ch3 = '0;
  logic in_stall;
  logic out_valid, out_last_pixel;
  logic out_stall = 1'b0;
  logic [7:0] out_mag_ch0, out_mag_ch1, out_mag_ch2, out_mag_ch3;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = sgm_pkg::CfgWidth;
  logic [15:0] cfg_data = '0;

  sobel_gradient_magnitude_core u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_pix_ch0, .in_pix_ch1, .in_pix_ch2, .in_pix_ch3,
    .out_valid, .out_stall, .out_mag_ch0, .out_mag_ch1, .out_mag_ch2, .out_mag_ch3,
    .out_last_pixel,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus store, expected results, pacing knobs
  pix_item_t   pixel_q[$];
  mag_result_t mag_q[$];
  pix_item_t   drv_item;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;

  // shadow of the registers and of the core's filter state
  logic [11:0] reg_width = sgm_pkg::WidthRst;
  logic [15:0] reg_height = sgm_pkg::HeightRst;
  logic [2:0]  reg_chan = sgm_pkg::ChanRst;
  logic        reg_gray = 1'b1;
  logic [31:0] row1_store [MaxW];
  logic [31:0] row2_store [MaxW];
  logic [31:0] win [9];
  int unsigned in_r, in_c, out_r, out_c;
  int unsigned lw = 640, lh = 480, lch = 3;
  bit          lgray = 1'b1;

  function automatic logic [7:0] root_sat(int unsigned v);
    int unsigned m;
    int unsigned b;
    m = 0;
    if (v >= 65025) return 8'd255;
    for (b = 128; b != 0; b = b >> 1)
      if ((m + b) * (m + b) <= v) m += b;
    return m[7:0];
  endfunction

  // Compute one result from a 3x3 window (index col*3+row) and advance the output position.
  function automatic bit push_magnitude(logic [31:0] w [9]);
    mag_result_t r;
    logic [7:0]  m [4];
    int          gx, gy;
    int          k;
    bit          last;
    for (k = 0; k < 4; k++) begin
      m[k] = 8'd0;
      if (k < lch) begin
        gx = int'(w[6][8*k+:8]) + 2 * int'(w[7][8*k+:8]) + int'(w[8][8*k+:8])
           - int'(w[0][8*k+:8]) - 2 * int'(w[1][8*k+:8]) - int'(w[2][8*k+:8]);
        gy = int'(w[2][8*k+:8]) + 2 * int'(w[5][8*k+:8]) + int'(w[8][8*k+:8])
           - int'(w[0][8*k+:8]) - 2 * int'(w[3][8*k+:8]) - int'(w[6][8*k+:8]);
        m[k] = root_sat(gx * gx + gy * gy);
      end
    end
    last = (out_r + 1 == lh) && (out_c + 1 == lw);
    r = '{m0: m[0], m1: m[1], m2: m[2], m3: m[3], last: last};
    mag_q.push_back(r);
    out_c++;
    if (out_c >= lw) begin
      out_c = 0;
      out_r++;
    end
    return last;
  endfunction

  // Advance the predicted core state by one accepted pixel transaction.
  function automatic void predict_pixel(pix_item_t it);
    logic [31:0] s, top, mid;
    logic [31:0] t [9];
    logic [7:0]  luma;
    int unsigned sum;
    bit          last;
    int          i;
    s = '0;
    last = 1'b0;
    if (in_r == 0 && in_c == 0) begin
      lw = (reg_width == 0) ? 1 : ((reg_width > MaxW) ? MaxW : reg_width);
      lh = (reg_height == 0) ? 1 : reg_height;
      lch = (reg_chan == 0) ? 1 :
            ((reg_chan > sgm_pkg::LanesDef) ? sgm_pkg::LanesDef : reg_chan);
      lgray = reg_gray && lch >= 3;
    end
    if (in_r < lh && it.cmd == CmdPixel) begin
      s[7:0] = it.ch0;
      if (lch > 1) s[15:8] = it.ch1;
      if (lch > 2) s[23:16] = it.ch2;
      if (lch > 3) s[31:24] = it.ch3;
      if (lgray) begin
        sum = (13933 * s[7:0] + 46871 * s[15:8] + 4732 * s[23:16]) >> 16;
        luma = sum[7:0];
        s = {s[31:24], luma, luma, luma};
      end
    end
    // column zero closes the previous row: emit its right-edge pixel first
    if (in_c == 0) begin
      if (in_r >= 2) begin
        for (i = 0; i < 9; i++) t[i] = (i < 6) ? win[i+3] : '0;
        last = push_magnitude(t);
      end
      for (i = 0; i < 9; i++) win[i] = '0;
    end
    top = (in_r >= 2) ? row2_store[in_c] : '0;
    mid = (in_r >= 1) ? row1_store[in_c] : '0;
    row2_store[in_c] = row1_store[in_c];
    row1_store[in_c] = s;
    for (i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = top;
    win[7] = mid;
    win[8] = s;
    if (in_c >= 1 && in_r >= 1) last = push_magnitude(win);
    in_c++;
    if (in_c >= lw) begin
      in_c = 0;
      in_r++;
    end
    if (last) begin
      in_r = 0;
      in_c = 0;
      out_r = 0;
      out_c = 0;
    end
  endfunction

  // Driver: predict on acceptance, then advance or idle; hold the payload while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_pixel(drv_item);
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pixel_q.pop_front();
          in_valid   <= 1'b1;
          in_cmd     <= drv_item.cmd;
          in_pix_ch0 <= drv_item.ch0;
          in_pix_ch1 <= drv_item.ch1;
          in_pix_ch2 <= drv_item.ch2;
          in_pix_ch3 <= drv_item.ch3;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    mag_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mag_q.size() == 0) begin
          $error("unexpected result: mag %0d %0d %0d %0d last %0b", out_mag_ch0,
                 out_mag_ch1, out_mag_ch2, out_mag_ch3, out_last_pixel);
          fail_cnt++;
        end else begin
          exp_r = mag_q.pop_front();
          if (out_mag_ch0 !== exp_r.m0) begin
            $error("mag_ch0 expected %0d actual %0d", exp_r.m0, out_mag_ch0);
            fail_cnt++;
          end
          if (out_mag_ch1 !== exp_r.m1) begin
            $error("mag_ch1 expected %0d actual %0d", exp_r.m1, out_mag_ch1);
            fail_cnt++;
          end
          if (out_mag_ch2 !== exp_r.m2) begin
            $error("mag_ch2 expected %0d actual %0d", exp_r.m2, out_mag_ch2);
            fail_cnt++;
          end
          if (out_mag_ch3 !== exp_r.m3) begin
            $error("mag_ch3 expected %0d actual %0d", exp_r.m3, out_mag_ch3);
            fail_cnt++;
          end
          if (out_last_pixel !== exp_r.last) begin
            $error("last_pixel expected %0b actual %0b", exp_r.last, out_last_pixel);
            fail_cnt++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TimeoutCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sgm_pkg::CfgWidth:  reg_width = val[11:0];
      sgm_pkg::CfgHeight: reg_height = val;
      sgm_pkg::CfgChan:   reg_chan = val[2:0];
      default:            reg_gray = val[0];
    endcase
  endtask

  // Wait until every transaction is taken and every result has come, then let the core settle.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || mag_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_sample(int mode);
    case (mode)
      1: return 8'd0;
      2: return 8'd255;
      3: return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Program the geometry, then queue a full image and the flush transactions that drain it.
  // Returns the number of transactions queued.
  task automatic run_image(input int w, input int h, input int ch, input bit gray,
                           input int mode, input int noise_pct, output int n_items);
    pix_item_t it;
    int        ew, eh, i;
    cfg_write(sgm_pkg::CfgWidth, {4'($urandom_range(15)), 12'(w)});
    cfg_write(sgm_pkg::CfgHeight, 16'(h));
    cfg_write(sgm_pkg::CfgChan, {13'($urandom_range(8191)), 3'(ch)});
    cfg_write(sgm_pkg::CfgGray, {15'($urandom_range(32767)), gray});
    ew = (w == 0) ? 1 : ((w > MaxW) ? MaxW : w);
    eh = (h == 0) ? 1 : h;
    for (i = 0; i < ew * eh + ew + 1; i++) begin
      it.ch0 = rand_sample(mode);
      it.ch1 = rand_sample(mode);
      it.ch2 = rand_sample(mode);
      it.ch3 = rand_sample(mode);
      // inside the image, an occasional flush acts as a zero pixel; past it, cmd is free
      if (i < ew * eh) it.cmd = ($urandom_range(99) < noise_pct) ? CmdFlush : CmdPixel;
      else it.cmd = 1'($urandom_range(1));
      pixel_q.push_back(it);
    end
    n_items = ew * eh + ew + 1;
    wait_idle();
  endtask

  initial begin
    int n, total, img;
    total = 0;
    img = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: tiny images, extremes, zero geometry, gray on and off, all channel counts.
    run_image(1, 1, 1, 1'b0, 2, 0, n);
    run_image(2, 2, 4, 1'b0, 3, 0, n);
    run_image(3, 3, 3, 1'b1, 3, 0, n);
    run_image(0, 0, 0, 1'b1, 2, 0, n);
    run_image(3, 2, 7, 1'b1, 0, 0, n);
    run_image(4, 2, 2, 1'b1, 1, 25, n);

    // Random images, rotating through the pacing phases.
    while (total < 750) begin
      case (img % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      run_image($urandom_range(1, 12), $urandom_range(0, 5), $urandom_range(0, 7),
                1'($urandom_range(1)), ($urandom_range(3) == 0) ? 3 : 0, 10, n);
      total += n;
      img++;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (fail_cnt == 0 && mag_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/sgm_pkg.sv
rtl/sgm_datapath.sv
rtl/sgm_ctrl.sv
rtl/sobel_gradient_magnitude_core.sv
tb/tb_sobel_gradient_magnitude_core.sv
